[rtl/mwf_pkg.sv]
package mwf_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_RADIUS = 3;
	localparam int MAX_ROWS   = 4096;

	// widths of the register fields as written on the configuration port
	localparam int CFG_RADIUS_W = 2;
	localparam int CFG_COLS_W   = 11;
	localparam int CFG_ROWS_W   = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;

	localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int LIN_W  = COLS_W + ROWS_W;

	// one line buffer row per window row plus the row being filled ahead of it,
	// rows addressed by row number modulo SLOTS
	localparam int SLOTS     = 2 * MAX_RADIUS + 2;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int ADDR_W    = SLOT_W + COL_W;
	localparam int MEM_DEPTH = SLOTS << COL_W;

	localparam int RST_RADIUS = 1;
	localparam int RST_COLS   = (512 <= MAX_COLS) ? 512 : MAX_COLS;
	localparam int RST_ROWS   = (512 <= MAX_ROWS) ? 512 : MAX_ROWS;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_COLS   = 2'd1,
		REG_ROWS   = 2'd2
	} mwf_reg_t;

	typedef struct packed {
		logic accept;
		logic decide;
		logic step;
		logic finish;
	} mwf_cmd_t;

	typedef struct packed {
		logic settling;
		logic due;
		logic scan_last;
		logic out_free;
	} mwf_stat_t;

endpackage

[rtl/midpoint_window_filter.sv]
// channel  direction  handshake            payload
// in       input      in_valid, in_ready   req_type, pixel_in
// out      output     out_valid, out_ready pixel_out, last_of_frame
// cfg      input      cfg_valid, cfg_ready cfg_index, cfg_data
//
// an item with no result goes IDLE, DECIDE and back to IDLE; an item with a result goes
// on through SCAN, DRAIN and RESULT over the clipped window (up to 49 pixels at radius 3),
// one read of the single line buffer per window pixel
// reset clears position counters and config registers; the line buffer needs no clear
// in_ready drops for one cycle after a config beat while frame size settles
// a stalled result sits in the output register; the next beat is still taken
module midpoint_window_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             req_type,
	input  logic [7:0]                       pixel_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       pixel_out,
	output logic                             last_of_frame,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mwf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mwf_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mwf_pkg::*;

	mwf_cmd_t  cmd;
	mwf_stat_t stat;

	mwf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mwf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_type      (req_type),
		.pixel_in      (pixel_in),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_out     (pixel_out),
		.last_of_frame (last_of_frame),
		.cmd           (cmd),
		.stat          (stat)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on two consecutive cycles");

	a_rose_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.finish))
		else $error("result appeared without a finished window");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input accepted before frame size settled");

	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !in_ready && !cmd.finish)
		else $error("scan overlaps accept or finish");

endmodule

[rtl/mwf_ctrl.sv]
module mwf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mwf_pkg::mwf_stat_t stat,
	output mwf_pkg::mwf_cmd_t  cmd
);
	import mwf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE) && !stat.settling;

	always_comb begin
		cmd.accept = in_valid && in_ready;
		cmd.decide = (state_q == ST_DECIDE);
		cmd.step   = (state_q == ST_SCAN);
		cmd.finish = (state_q == ST_RESULT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= stat.due ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (stat.scan_last) state_q <= ST_DRAIN;
				end
				// last read beat still in flight
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/mwf_datapath.sv]
module mwf_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_type,
	input  logic [7:0]                       pixel_in,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mwf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mwf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       pixel_out,
	output logic                             last_of_frame,
	input  mwf_pkg::mwf_cmd_t                cmd,
	output mwf_pkg::mwf_stat_t               stat
);
	import mwf_pkg::*;

	localparam int RSUM_W = ROWS_W + 1;
	localparam int CSUM_W = COLS_W + 1;

	logic [RAD_W-1:0]  radius_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] rows_q;
	logic              settle_q;
	logic [LIN_W-1:0]  total_q;
	logic [LIN_W-1:0]  lag_q;

	logic [COL_W-1:0]  in_col_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [LIN_W-1:0]  in_lin_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [LIN_W-1:0]  out_lin_q;

	logic [ROW_W-1:0]  i_q;
	logic [ROW_W-1:0]  r1_q;
	logic [COL_W-1:0]  j_q;
	logic [COL_W-1:0]  c0_q;
	logic [COL_W-1:0]  c1_q;
	logic [SLOT_W-1:0] slot_i_q;
	logic [7:0]        mn_q;
	logic [7:0]        mx_q;

	logic [7:0]        line_store_q [MEM_DEPTH];
	logic [7:0]        rd_data_s1;
	logic              rd_vld_s1;

	logic              out_valid_q;
	logic [7:0]        pix_out_q;
	logic              last_q;

	logic              cfg_hit;
	logic              pix_write;
	logic              last_next;
	logic [LIN_W:0]    ahead;
	logic [ROW_W-1:0]  r0;
	logic [ROW_W-1:0]  r1;
	logic [COL_W-1:0]  c0;
	logic [COL_W-1:0]  c1;
	logic [RAD_W-1:0]  dr;
	logic [SLOT_W-1:0] slot0;
	logic [RSUM_W-1:0] rsum;
	logic [CSUM_W-1:0] csum;
	logic [8:0]        mid_sum;

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign pixel_out     = pix_out_q;
	assign last_of_frame = last_q;

	always_comb begin
		case (cfg_index)
			REG_RADIUS: cfg_hit = cfg_valid;
			REG_COLS:   cfg_hit = cfg_valid;
			REG_ROWS:   cfg_hit = cfg_valid;
			default:    cfg_hit = 1'b0;
		endcase
	end

	assign pix_write = !req_type && (in_lin_q < total_q);
	assign last_next = (out_lin_q + LIN_W'(1)) == total_q;
	assign ahead     = {1'b0, out_lin_q} + {1'b0, lag_q};

	always_comb begin
		stat.settling  = settle_q;
		stat.due       = (out_lin_q < total_q)
		              && ((in_lin_q == total_q) || ({1'b0, in_lin_q} > ahead));
		stat.scan_last = (i_q == r1_q) && (j_q == c1_q);
		stat.out_free  = !out_valid_q || out_ready;
	end

	// window bounds, clipped to the image
	always_comb begin
		if (out_row_q >= ROW_W'(radius_q)) begin
			r0 = out_row_q - ROW_W'(radius_q);
			dr = radius_q;
		end else begin
			r0 = '0;
			dr = RAD_W'(out_row_q);
		end
		rsum = RSUM_W'(out_row_q) + RSUM_W'(radius_q);
		r1 = (rsum < RSUM_W'(rows_q)) ? ROW_W'(rsum) : ROW_W'(rows_q - ROWS_W'(1));
		c0 = (out_col_q >= COL_W'(radius_q)) ? out_col_q - COL_W'(radius_q) : '0;
		csum = CSUM_W'(out_col_q) + CSUM_W'(radius_q);
		c1 = (csum < CSUM_W'(cols_q)) ? COL_W'(csum) : COL_W'(cols_q - COLS_W'(1));
		// wraps modulo the slot count, true value stays below SLOTS
		if (out_slot_q >= SLOT_W'(dr))
			slot0 = out_slot_q - SLOT_W'(dr);
		else
			slot0 = out_slot_q + SLOT_W'(SLOTS) - SLOT_W'(dr);
	end

	assign mid_sum = {1'b0, mn_q} + {1'b0, mx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_W'(RST_RADIUS);
			cols_q   <= COLS_W'(RST_COLS);
			rows_q   <= ROWS_W'(RST_ROWS);
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_valid;
			if (cfg_valid) begin
				case (cfg_index)
					REG_RADIUS: begin
						if (32'(cfg_data[CFG_RADIUS_W-1:0]) > MAX_RADIUS)
							radius_q <= RAD_W'(MAX_RADIUS);
						else
							radius_q <= RAD_W'(cfg_data[CFG_RADIUS_W-1:0]);
					end
					REG_COLS: begin
						if (cfg_data[CFG_COLS_W-1:0] == '0)
							cols_q <= COLS_W'(1);
						else if (32'(cfg_data[CFG_COLS_W-1:0]) > MAX_COLS)
							cols_q <= COLS_W'(MAX_COLS);
						else
							cols_q <= COLS_W'(cfg_data[CFG_COLS_W-1:0]);
					end
					REG_ROWS: begin
						if (cfg_data[CFG_ROWS_W-1:0] == '0)
							rows_q <= ROWS_W'(1);
						else if (32'(cfg_data[CFG_ROWS_W-1:0]) > MAX_ROWS)
							rows_q <= ROWS_W'(MAX_ROWS);
						else
							rows_q <= ROWS_W'(cfg_data[CFG_ROWS_W-1:0]);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// frame size and output lag, registered from the stored radius and sizes after a write
	always_ff @(posedge clk) begin
		total_q <= LIN_W'(rows_q) * LIN_W'(cols_q);
		lag_q   <= LIN_W'(radius_q) * LIN_W'(cols_q) + LIN_W'(radius_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_slot_q   <= '0;
			in_lin_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_slot_q  <= '0;
			out_lin_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_hit) begin
			in_col_q    <= '0;
			in_slot_q   <= '0;
			in_lin_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_slot_q  <= '0;
			out_lin_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && pix_write) begin
				if (COLS_W'(in_col_q) + COLS_W'(1) == cols_q) begin
					in_col_q  <= '0;
					in_slot_q <= (in_slot_q == SLOT_W'(SLOTS - 1)) ? '0
					           : in_slot_q + SLOT_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				in_lin_q <= in_lin_q + LIN_W'(1);
			end
			if (cmd.finish) begin
				if (last_next) begin
					in_col_q   <= '0;
					in_slot_q  <= '0;
					in_lin_q   <= '0;
					out_row_q  <= '0;
					out_col_q  <= '0;
					out_slot_q <= '0;
					out_lin_q  <= '0;
				end else begin
					if (COLS_W'(out_col_q) + COLS_W'(1) == cols_q) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + ROW_W'(1);
						out_slot_q <= (out_slot_q == SLOT_W'(SLOTS - 1)) ? '0
						            : out_slot_q + SLOT_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
					out_lin_q <= out_lin_q + LIN_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && pix_write)
			line_store_q[{in_slot_q, in_col_q}] <= pixel_in;
		if (cmd.step)
			rd_data_s1 <= line_store_q[{slot_i_q, j_q}];
	end

	// window scan, one pixel per cycle, row by row
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			i_q      <= r0;
			r1_q     <= r1;
			j_q      <= c0;
			c0_q     <= c0;
			c1_q     <= c1;
			slot_i_q <= slot0;
			mn_q     <= 8'hFF;
			mx_q     <= 8'h00;
		end else begin
			if (cmd.step) begin
				if (j_q == c1_q) begin
					j_q      <= c0_q;
					i_q      <= i_q + ROW_W'(1);
					slot_i_q <= (slot_i_q == SLOT_W'(SLOTS - 1)) ? '0
					          : slot_i_q + SLOT_W'(1);
				end else begin
					j_q <= j_q + COL_W'(1);
				end
			end
			if (rd_vld_s1) begin
				if (rd_data_s1 < mn_q) mn_q <= rd_data_s1;
				if (rd_data_s1 > mx_q) mx_q <= rd_data_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pix_out_q <= mid_sum[8:1];
			last_q    <= last_next;
		end
	end

endmodule

[verif/tb_top.sv]
module tb_top;
	import mwf_pkg::*;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int RING_DEPTH = (2 * MAX_RADIUS + 1) * (MAX_COLS + 1);
	localparam int SETTLE = 60;
	localparam int RANDOM_ITEMS = 450;

	typedef struct {
		logic       flush;
		logic [7:0] px;
	} px_item_t;

	typedef struct {
		logic [7:0] mid;
		logic       last;
	} mid_beat_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   req_type = REQ_PIXEL;
	logic [7:0]             pixel_in = 8'd0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [7:0]             pixel_out;
	logic                   last_of_frame;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	px_item_t  items_todo[$];
	mid_beat_t mids_due[$];
	int        fail_count = 0;

	// filter state as the block should hold it
	logic [7:0]  ring_px [RING_DEPTH];
	int unsigned f_rad = RST_RADIUS;
	int unsigned f_cols = RST_COLS;
	int unsigned f_rows = RST_ROWS;
	int unsigned in_r = 0, in_c = 0, out_r = 0, out_c = 0;

	always #5 clk = ~clk;

	midpoint_window_filter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.pixel_in      (pixel_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_out     (pixel_out),
		.last_of_frame (last_of_frame),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	function automatic void rewind_frame();
		in_r = 0;
		in_c = 0;
		out_r = 0;
		out_c = 0;
	endfunction

	function automatic void step_pos(inout int unsigned row, inout int unsigned col);
		col++;
		if (col >= f_cols) begin
			col = 0;
			row++;
		end
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		int unsigned v;
		case (idx)
		REG_RADIUS: begin
			v = 32'(data[CFG_RADIUS_W-1:0]);
			f_rad = (v > MAX_RADIUS) ? MAX_RADIUS : v;
		end
		REG_COLS: begin
			v = 32'(data[CFG_COLS_W-1:0]);
			if (v == 0) v = 1;
			f_cols = (v > MAX_COLS) ? MAX_COLS : v;
		end
		REG_ROWS: begin
			v = 32'(data[CFG_ROWS_W-1:0]);
			if (v == 0) v = 1;
			f_rows = (v > MAX_ROWS) ? MAX_ROWS : v;
		end
		default: return;
		endcase
		rewind_frame();
	endfunction

	function automatic logic [7:0] window_mid(int unsigned row, int unsigned col);
		int unsigned r0, r1, c0, c1, lo, hi, v;
		r0 = (row >= f_rad) ? row - f_rad : 0;
		r1 = (row + f_rad < f_rows) ? row + f_rad : f_rows - 1;
		c0 = (col >= f_rad) ? col - f_rad : 0;
		c1 = (col + f_rad < f_cols) ? col + f_rad : f_cols - 1;
		lo = 255;
		hi = 0;
		for (int unsigned i = r0; i <= r1; i++) begin
			for (int unsigned j = c0; j <= c1; j++) begin
				v = 32'(ring_px[(i * f_cols + j) % RING_DEPTH]);
				if (v < lo) lo = v;
				if (v > hi) hi = v;
			end
		end
		return 8'((lo + hi) >> 1);
	endfunction

	function automatic void track_item(logic flush, logic [7:0] px);
		int unsigned total, in_lin, out_lin, lag;
		mid_beat_t b;
		total = f_rows * f_cols;
		in_lin = in_r * f_cols + in_c;
		out_lin = out_r * f_cols + out_c;
		lag = f_rad * f_cols + f_rad;
		// a pixel past the frame end is only a flush
		if (flush == REQ_PIXEL && in_lin < total) begin
			ring_px[in_lin % RING_DEPTH] = px;
			step_pos(in_r, in_c);
			in_lin++;
		end
		if (out_lin >= total || !(in_lin == total || in_lin > out_lin + lag))
			return;
		b.mid = window_mid(out_r, out_c);
		b.last = (out_lin + 1 == total);
		mids_due.push_back(b);
		if (b.last)
			rewind_frame();
		else
			step_pos(out_r, out_c);
	endfunction

	// input driver: bursts of beats with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		logic     nxt_valid;
		px_item_t it;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				track_item(req_type, pixel_in);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (items_todo.size() > 0) begin
					it = items_todo.pop_front();
					req_type <= it.flush;
					pixel_in <= it.px;
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// long bursts give stretches with no idling
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
							: $urandom_range(0, 12);
						gap_left = $urandom_range(0, 8);
					end
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// result monitor with its own stall pattern
	rx_mode_t rx_mode = RX_OPEN;
	int       mode_left = 0;
	int       tick = 0;

	always @(posedge clk) begin
		mid_beat_t want;
		logic      nxt_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (mids_due.size() == 0) begin
					$display("%0t: unexpected beat pixel_out=%0d last_of_frame=%0b",
						$time, pixel_out, last_of_frame);
					fail_count++;
				end else begin
					want = mids_due.pop_front();
					if (pixel_out !== want.mid) begin
						$display("%0t: pixel_out expected %0d actual %0d",
							$time, want.mid, pixel_out);
						fail_count++;
					end
					if (last_of_frame !== want.last) begin
						$display("%0t: last_of_frame expected %0b actual %0b",
							$time, want.last, last_of_frame);
						fail_count++;
					end
				end
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			tick++;
			case (rx_mode)
			RX_OPEN:   nxt_ready = 1'b1;
			RX_COIN:   nxt_ready = 1'($urandom_range(0, 1));
			RX_SPARSE: nxt_ready = ($urandom_range(0, 3) == 0);
			default:   nxt_ready = (tick % 7) < 3;
			endcase
			out_ready <= nxt_ready;
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (items_todo.size() != 0 || in_valid || mids_due.size() != 0)
			@(negedge clk);
		// items without a result may still be in the pipe
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
	endtask

	task automatic push_item(logic flush, logic [7:0] px);
		px_item_t it;
		it.flush = flush;
		it.px = px;
		items_todo.push_back(it);
	endtask

	// one whole frame with stray flushes, then the drain; returns beats that count
	task automatic push_frame(int unsigned rad, int unsigned cols, int unsigned rows,
		inout int counted);
		int unsigned total, lag, drain;
		total = rows * cols;
		lag = rad * cols + rad;
		for (int unsigned k = 0; k < total; k++) begin
			if ($urandom_range(0, 9) == 0) push_item(REQ_FLUSH, 8'($urandom));
			push_item(REQ_PIXEL, 8'($urandom_range(0, 255)));
		end
		drain = (total > lag) ? lag : total - 1;
		for (int unsigned k = 0; k < drain; k++)
			push_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 2)) push_item(REQ_FLUSH, 8'($urandom));
		counted += total + drain;
	endtask

	initial begin
		int          counted;
		int unsigned rad, cols, rows, nframes;
		counted = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small frame; upper radius bits must be masked, spare index ignored
		write_reg(REG_RADIUS, 13'h1FFD);
		write_reg(REG_COLS, 13'd4);
		write_reg(REG_ROWS, 13'd3);
		write_reg(REG_SPARE, 13'h1FFF);
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_item(REQ_FLUSH, 8'h00); // flush before frame end
		push_item(REQ_PIXEL, 8'h00);
		push_item(REQ_PIXEL, 8'hFF);
		push_item(REQ_PIXEL, 8'h55);
		push_item(REQ_PIXEL, 8'hAA);
		push_item(REQ_PIXEL, 8'h0F);
		push_item(REQ_PIXEL, 8'hF0);
		push_item(REQ_PIXEL, 8'h01);
		push_item(REQ_PIXEL, 8'hFE);
		push_item(REQ_PIXEL, 8'h80);
		push_item(REQ_PIXEL, 8'h7F);
		push_item(REQ_PIXEL, 8'h40);
		push_item(REQ_PIXEL, 8'hC8);
		push_item(REQ_FLUSH, 8'hFF);
		push_item(REQ_PIXEL, 8'h33); // pixel after frame end drains
		push_item(REQ_FLUSH, 8'h00);
		push_item(REQ_FLUSH, 8'h00);
		push_item(REQ_FLUSH, 8'h00);

		// saturating sizes, zero radius; partial frame cut by the next write
		wait_idle();
		write_reg(REG_RADIUS, 13'd0);
		write_reg(REG_COLS, 13'h07FF);
		write_reg(REG_ROWS, 13'h1FFF);
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_item(REQ_PIXEL, 8'd9);
		push_item(REQ_PIXEL, 8'd250);
		push_item(REQ_PIXEL, 8'd77);

		// zero sizes act as one: single pixel frames at the widest radius
		wait_idle();
		write_reg(REG_RADIUS, 13'd3);
		write_reg(REG_COLS, 13'd0);
		write_reg(REG_ROWS, 13'd0);
		cfg_valid <= 1'b0;
		@(negedge clk);
		push_item(REQ_PIXEL, 8'd200);
		push_item(REQ_PIXEL, 8'd17);

		while (counted < RANDOM_ITEMS) begin
			wait_idle();
			rad = $urandom_range(0, 3);
			cols = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
			rows = (cols <= 4) ? $urandom_range(1, 12) : $urandom_range(1, 6);
			write_reg(REG_RADIUS, 13'(($urandom_range(0, 2047) << 2) | rad));
			write_reg(REG_COLS, 13'(($urandom_range(0, 3) << 11) | cols));
			if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 13'($urandom));
			write_reg(REG_ROWS, 13'(rows));
			cfg_valid <= 1'b0;
			@(negedge clk);
			nframes = $urandom_range(1, 3);
			for (int unsigned f = 0; f < nframes; f++)
				push_frame(rad, cols, rows, counted);
			// broken frame, dropped by the next register write
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 8))
					push_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end

		wait_idle();
		if (fail_count == 0 && mids_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
rtl/mwf_pkg.sv
rtl/mwf_ctrl.sv
rtl/mwf_datapath.sv
rtl/midpoint_window_filter.sv
verif/tb_top.sv
